/* hw/rtl/target_track_qualifier_core_macros.svh */
// ----------------------------------------------------------------------------
// Target track qualifier assertion macros
// Assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TARGET_TRACK_QUALIFIER_CORE_MACROS_SVH
`define TARGET_TRACK_QUALIFIER_CORE_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define TTQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define TTQ_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TTQ_ASSERT(lbl, clk, rst, prop, msg)
`define TTQ_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

/* hw/rtl/ttq_pkg.sv */
// ----------------------------------------------------------------------------
// Target track qualifier package
// Shared widths, register indexes, state encodings and control structs.
// ----------------------------------------------------------------------------
package ttq_pkg;

   // parameter defaults
   localparam int ANGLE_BITS_DEF = 16;
   localparam int POS_BITS_DEF   = 16;
   localparam int COUNT_BITS_DEF = 8;

   // fixed field widths
   localparam int CFG_COUNT_BITS = 8;
   localparam int COLOR_BITS     = 2;
   localparam int OFFSET_BITS    = 16;
   localparam int TIME_BITS      = 32;
   localparam int RANGE_BITS     = 16;
   localparam int COAST_BITS     = 9;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [RANGE_BITS-1:0] RANGE_MAX = '1;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_CONFIRM_NEED = 2'd0;
   localparam logic [1:0] REG_MAX_COAST    = 2'd1;
   localparam logic [1:0] REG_FOE_COLOR    = 2'd2;

   // register reset values
   localparam logic [CFG_COUNT_BITS-1:0] CONFIRM_NEED_RST = 8'd3;
   localparam logic [CFG_COUNT_BITS-1:0] MAX_COAST_RST    = 8'd5;
   localparam logic [COLOR_BITS-1:0]     FOE_COLOR_RST    = 2'd0;

   // color code that matches anything
   localparam logic [COLOR_BITS-1:0] COLOR_UNKNOWN = 2'd0;

   // last squaring step (three products, one final accumulate)
   localparam logic [1:0] SQ_LAST = 2'd3;

   typedef enum logic [1:0] {
      MODE_LOST      = 2'd0,
      MODE_DETECTING = 2'd1,
      MODE_TRACKING  = 2'd2,
      MODE_COAST     = 2'd3
   } track_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SQUARE = 2'd1,
      ST_ROOT   = 2'd2,
      ST_REPLY  = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic [CFG_COUNT_BITS-1:0] confirm_need;
      logic [CFG_COUNT_BITS-1:0] max_coast;
      logic [COLOR_BITS-1:0]     foe_color;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic       item_ready;
      logic       sq_step;
      logic [1:0] sq_idx;
      logic       root_step;
      logic       rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_valid;
      logic frame_end;
      logic need_range;
      logic rsp_free;
   } status_type;

endpackage

/* hw/rtl/ttq_if.sv */
// ----------------------------------------------------------------------------
// Target track qualifier channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface ttq_req_if import ttq_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int POS_BITS   = POS_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic                         present;
   logic                         solved;
   logic [COLOR_BITS-1:0]        det_color;
   logic [OFFSET_BITS-1:0]       center_offset;
   logic signed [ANGLE_BITS-1:0] yaw_in;
   logic signed [ANGLE_BITS-1:0] pitch_in;
   logic signed [POS_BITS-1:0]   pos_x;
   logic signed [POS_BITS-1:0]   pos_y;
   logic signed [POS_BITS-1:0]   pos_z;
   logic                         frame_end;
   logic [TIME_BITS-1:0]         frame_time;

   modport source (
      output valid, present, solved, det_color, center_offset, yaw_in, pitch_in,
             pos_x, pos_y, pos_z, frame_end, frame_time,
      input  ready
   );
   modport sink (
      input  valid, present, solved, det_color, center_offset, yaw_in, pitch_in,
             pos_x, pos_y, pos_z, frame_end, frame_time,
      output ready
   );
endinterface

interface ttq_rsp_if import ttq_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic                         tracking;
   logic signed [ANGLE_BITS-1:0] yaw_out;
   logic signed [ANGLE_BITS-1:0] pitch_out;
   logic [RANGE_BITS-1:0]        range_out;
   logic [TIME_BITS-1:0]         time_out;
   logic [1:0]                   track_state;

   modport source (
      output valid, tracking, yaw_out, pitch_out, range_out, time_out, track_state,
      input  ready
   );
   modport sink (
      input  valid, tracking, yaw_out, pitch_out, range_out, time_out, track_state,
      output ready
   );
endinterface

/* hw/rtl/ttq_regs.sv */
// ----------------------------------------------------------------------------
// Target track qualifier register file
// APB-style configuration registers, zero-wait writes and reads.
// ----------------------------------------------------------------------------
module ttq_regs import ttq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   logic [CFG_COUNT_BITS-1:0] confirm_need_ff, confirm_need_in;
   logic [CFG_COUNT_BITS-1:0] max_coast_ff, max_coast_in;
   logic [COLOR_BITS-1:0]     foe_color_ff, foe_color_in;
   logic                      wr_en;
   logic [1:0]                reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // write decode
   always_comb begin
      confirm_need_in = confirm_need_ff;
      max_coast_in    = max_coast_ff;
      foe_color_in    = foe_color_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CONFIRM_NEED: confirm_need_in = pwdata[CFG_COUNT_BITS-1:0];
            REG_MAX_COAST:    max_coast_in    = pwdata[CFG_COUNT_BITS-1:0];
            REG_FOE_COLOR:    foe_color_in    = pwdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_need_ff <= CONFIRM_NEED_RST;
         max_coast_ff    <= MAX_COAST_RST;
         foe_color_ff    <= FOE_COLOR_RST;
      end else begin
         confirm_need_ff <= confirm_need_in;
         max_coast_ff    <= max_coast_in;
         foe_color_ff    <= foe_color_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_CONFIRM_NEED: prdata = CSR_DATA_BITS'(confirm_need_ff);
         REG_MAX_COAST:    prdata = CSR_DATA_BITS'(max_coast_ff);
         REG_FOE_COLOR:    prdata = CSR_DATA_BITS'(foe_color_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.confirm_need = confirm_need_ff;
   assign cfg.max_coast    = max_coast_ff;
   assign cfg.foe_color    = foe_color_ff;

endmodule

/* hw/rtl/ttq_ctrl.sv */
// ----------------------------------------------------------------------------
// Target track qualifier controller
// Sequences request intake, range squaring, square root and reply.
// ----------------------------------------------------------------------------
`include "target_track_qualifier_core_macros.svh"

module ttq_ctrl import ttq_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int STEP_BITS = $clog2(POS_BITS);
   localparam logic [STEP_BITS-1:0] ROOT_LAST = STEP_BITS'(POS_BITS - 1);
   localparam logic [STEP_BITS-1:0] SQ_END    = STEP_BITS'(SQ_LAST);

   seq_state_type        state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid && status.frame_end) begin
               state_in = status.need_range ? ST_SQUARE : ST_REPLY;
            end
         end
         ST_SQUARE: begin
            if (step_ff == SQ_END) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == ROOT_LAST) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // step counter, shared by squaring and root iterations
   always_comb begin
      step_in = '0;
      if (state_ff == ST_SQUARE && step_ff != SQ_END) begin
         step_in = step_ff + 1'b1;
      end else if (state_ff == ST_ROOT && step_ff != ROOT_LAST) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // commands
   always_comb begin
      cmd.item_ready = (state_ff == ST_IDLE);
      cmd.sq_step    = (state_ff == ST_SQUARE);
      cmd.sq_idx     = step_ff[1:0];
      cmd.root_step  = (state_ff == ST_ROOT);
      cmd.rsp_load   = (state_ff == ST_REPLY) && status.rsp_free;
   end

   `TTQ_ASSERT(a_sq_to_root, clock, reset, state_ff == ST_SQUARE && step_ff == SQ_END |=> state_ff == ST_ROOT, "squaring did not hand over to root")
   `TTQ_ASSERT(a_reply_holds, clock, reset, state_ff == ST_REPLY && !status.rsp_free |=> state_ff == ST_REPLY, "reply left while output full")
   `TTQ_ASSERT(a_short_frame, clock, reset, state_ff == ST_IDLE && status.req_valid && status.frame_end && !status.need_range |=> state_ff == ST_REPLY, "frame end without range skipped reply")

endmodule

/* hw/rtl/ttq_datapath.sv */
// ----------------------------------------------------------------------------
// Target track qualifier datapath
// Best-detection capture, tracker update, range square root, output register.
// ----------------------------------------------------------------------------
`include "target_track_qualifier_core_macros.svh"

module ttq_datapath import ttq_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int POS_BITS   = POS_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   ttq_req_if.sink    req_chan,
   ttq_rsp_if.source  rsp_chan
);

   localparam int SUM_BITS = 2 * POS_BITS;
   localparam int REM_BITS = POS_BITS + 1;
   localparam int TRY_BITS = POS_BITS + 3;
   localparam int CMP_BITS = (COUNT_BITS > CFG_COUNT_BITS) ? COUNT_BITS : CFG_COUNT_BITS;
   localparam int RW_BITS  = (POS_BITS > RANGE_BITS) ? POS_BITS : RANGE_BITS;

   // frame selection state
   logic                   frame_found_ff, frame_found_in;
   logic [OFFSET_BITS-1:0] best_offset_ff;
   logic [ANGLE_BITS-1:0]  best_yaw_ff, best_pitch_ff;
   logic [POS_BITS-1:0]    best_x_ff, best_y_ff, best_z_ff;

   // tracker state
   track_mode_type         mode_ff, mode_in;
   logic [COUNT_BITS-1:0]  confirm_ff, confirm_in, confirm_inc;
   logic [COAST_BITS-1:0]  coast_ff, coast_in, coast_inc;
   logic [ANGLE_BITS-1:0]  held_yaw_ff, held_pitch_ff;
   logic [RANGE_BITS-1:0]  held_range_ff;

   // reply staging
   logic                   pend_trk_ff, pend_range_ff;
   logic [TIME_BITS-1:0]   pend_time_ff;
   track_mode_type         pend_state_ff;

   // range unit
   logic [POS_BITS-1:0]    sq_sel, mag;
   logic [SUM_BITS-1:0]    prod_in, prod_ff, sum_ff, op_ff;
   logic [REM_BITS-1:0]    rem_ff;
   logic [POS_BITS-1:0]    root_ff;
   logic [TRY_BITS-1:0]    rem_shift, trial;
   logic [RW_BITS-1:0]     root_ext;
   logic [RANGE_BITS-1:0]  root_sat;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_trk_ff;
   logic [ANGLE_BITS-1:0]  rsp_yaw_ff, rsp_pitch_ff;
   logic [RANGE_BITS-1:0]  rsp_range_ff, rsp_range_in;
   logic [TIME_BITS-1:0]   rsp_time_ff;
   track_mode_type         rsp_state_ff;

   logic                   accept, color_ok, take, better, capture, best_now;
   logic                   frame_close, need_range, trk_now;
   logic [ANGLE_BITS-1:0]  pick_yaw, pick_pitch;

   // candidate qualification
   assign accept   = req_chan.valid & cmd.item_ready;
   assign color_ok = (cfg.foe_color == COLOR_UNKNOWN) ||
                     (req_chan.det_color == COLOR_UNKNOWN) ||
                     (req_chan.det_color == cfg.foe_color);
   assign take     = accept & req_chan.present & req_chan.solved & color_ok;
   assign better   = !frame_found_ff || (req_chan.center_offset < best_offset_ff);
   assign capture  = take & better;
   assign best_now = frame_found_ff | take;
   assign frame_close = accept & req_chan.frame_end;

   assign pick_yaw   = capture ? req_chan.yaw_in : best_yaw_ff;
   assign pick_pitch = capture ? req_chan.pitch_in : best_pitch_ff;

   always_comb begin
      frame_found_in = frame_found_ff;
      if (frame_close) frame_found_in = 1'b0;
      else if (take)   frame_found_in = 1'b1;
   end

   // best detection store, no reset
   always_ff @(posedge clock) begin
      if (capture) begin
         best_offset_ff <= req_chan.center_offset;
         best_yaw_ff    <= req_chan.yaw_in;
         best_pitch_ff  <= req_chan.pitch_in;
         best_x_ff      <= req_chan.pos_x;
         best_y_ff      <= req_chan.pos_y;
         best_z_ff      <= req_chan.pos_z;
      end
   end

   // tracker update at frame end
   assign confirm_inc = (confirm_ff == '1) ? confirm_ff : confirm_ff + 1'b1;
   assign coast_inc   = coast_ff + 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      confirm_in = confirm_ff;
      coast_in   = coast_ff;
      if (frame_close) begin
         unique case (mode_ff)
            MODE_LOST: begin
               if (best_now) begin
                  mode_in    = MODE_DETECTING;
                  confirm_in = COUNT_BITS'(1);
               end
            end
            MODE_DETECTING: begin
               if (best_now) begin
                  confirm_in = confirm_inc;
                  if (CMP_BITS'(confirm_inc) >= CMP_BITS'(cfg.confirm_need)) begin
                     mode_in = MODE_TRACKING;
                  end
               end else begin
                  mode_in    = MODE_LOST;
                  confirm_in = '0;
               end
            end
            MODE_TRACKING: begin
               if (!best_now) begin
                  mode_in  = MODE_COAST;
                  coast_in = COAST_BITS'(1);
               end
            end
            MODE_COAST: begin
               if (best_now) begin
                  mode_in  = MODE_TRACKING;
                  coast_in = '0;
               end else if (coast_inc > COAST_BITS'(cfg.max_coast)) begin
                  mode_in  = MODE_LOST;
                  coast_in = '0;
               end else begin
                  coast_in = coast_inc;
               end
            end
            default: mode_in = MODE_LOST;
         endcase
      end
   end

   assign need_range = frame_close & best_now & (mode_in == MODE_TRACKING);
   assign trk_now    = (mode_in == MODE_TRACKING) || (mode_in == MODE_COAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_found_ff <= 1'b0;
         mode_ff        <= MODE_LOST;
         confirm_ff     <= '0;
         coast_ff       <= '0;
         held_yaw_ff    <= '0;
         held_pitch_ff  <= '0;
      end else begin
         frame_found_ff <= frame_found_in;
         mode_ff        <= mode_in;
         confirm_ff     <= confirm_in;
         coast_ff       <= coast_in;
         if (need_range) begin
            held_yaw_ff   <= pick_yaw;
            held_pitch_ff <= pick_pitch;
         end
      end
   end

   // reply staging, loaded on the frame-end request
   always_ff @(posedge clock) begin
      if (frame_close) begin
         pend_trk_ff   <= trk_now;
         pend_range_ff <= need_range;
         pend_time_ff  <= req_chan.frame_time;
         pend_state_ff <= mode_in;
      end
   end

   // squaring: one product per step, accumulate one step behind
   always_comb begin
      unique case (cmd.sq_idx)
         2'd0:    sq_sel = best_x_ff;
         2'd1:    sq_sel = best_y_ff;
         default: sq_sel = best_z_ff;
      endcase
   end

   assign mag     = sq_sel[POS_BITS-1] ? (~sq_sel + 1'b1) : sq_sel;
   assign prod_in = SUM_BITS'(mag) * SUM_BITS'(mag);

   // root: one result bit per step
   assign rem_shift = {rem_ff, op_ff[SUM_BITS-1 -: 2]};
   assign trial     = rem_shift - {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sq_step) begin
         if (cmd.sq_idx != SQ_LAST) prod_ff <= prod_in;
         if (cmd.sq_idx == 2'd0) begin
            sum_ff <= '0;
         end else if (cmd.sq_idx != SQ_LAST) begin
            sum_ff <= sum_ff + prod_ff;
         end else begin
            op_ff   <= sum_ff + prod_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
      end else if (cmd.root_step) begin
         op_ff <= op_ff << 2;
         if (!trial[TRY_BITS-1]) begin
            rem_ff  <= trial[REM_BITS-1:0];
            root_ff <= {root_ff[POS_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[REM_BITS-1:0];
            root_ff <= {root_ff[POS_BITS-2:0], 1'b0};
         end
      end
   end

   // saturate root to range width
   assign root_ext = RW_BITS'(root_ff);
   assign root_sat = (root_ext > RW_BITS'(RANGE_MAX)) ? RANGE_MAX : root_ext[RANGE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         held_range_ff <= '0;
      end else if (cmd.rsp_load && pend_range_ff) begin
         held_range_ff <= root_sat;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)        rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      if (!pend_trk_ff)       rsp_range_in = '0;
      else if (pend_range_ff) rsp_range_in = root_sat;
      else                    rsp_range_in = held_range_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_trk_ff   <= pend_trk_ff;
         rsp_yaw_ff   <= pend_trk_ff ? held_yaw_ff : '0;
         rsp_pitch_ff <= pend_trk_ff ? held_pitch_ff : '0;
         rsp_range_ff <= rsp_range_in;
         rsp_time_ff  <= pend_time_ff;
         rsp_state_ff <= pend_state_ff;
      end
   end

   assign req_chan.ready       = cmd.item_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tracking    = rsp_trk_ff;
   assign rsp_chan.yaw_out     = rsp_yaw_ff;
   assign rsp_chan.pitch_out   = rsp_pitch_ff;
   assign rsp_chan.range_out   = rsp_range_ff;
   assign rsp_chan.time_out    = rsp_time_ff;
   assign rsp_chan.track_state = rsp_state_ff;

   // status to controller
   always_comb begin
      status.req_valid  = req_chan.valid;
      status.frame_end  = req_chan.frame_end;
      status.need_range = need_range;
      status.rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   `TTQ_ASSERT_NEVER(a_coast_mode, clock, reset, coast_ff != '0 && mode_ff != MODE_COAST, "coast count outside coasting")
   `TTQ_ASSERT(a_trk_flag, clock, reset, rsp_valid_ff |-> (rsp_trk_ff == (rsp_state_ff == MODE_TRACKING || rsp_state_ff == MODE_COAST)), "tracking flag disagrees with state")
   `TTQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff, "response dropped before it was taken")

endmodule

/* hw/rtl/target_track_qualifier_core.sv */
// ----------------------------------------------------------------------------
// Target track qualifier core
// Non-frame-end requests: accepted back to back while the sequencer is idle, no response.
// Frame-end request: one response, after the squaring and root steps when range is
// needed (4 squaring steps on one multiplier, one root bit per cycle).
// Synchronous active-high reset: tracker lost, counters and held values zero.
// ----------------------------------------------------------------------------
module target_track_qualifier_core import ttq_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int POS_BITS   = POS_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   ttq_req_if.sink                  req_chan,
   ttq_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   ttq_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   ttq_ctrl #(
      .POS_BITS (POS_BITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // selection, tracker and range datapath
   ttq_datapath #(
      .ANGLE_BITS (ANGLE_BITS),
      .POS_BITS   (POS_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
